FILE: hw/rtl/hkr_pkg.sv
// ----------------------------------------------------------------------------
// hkr_pkg
// Shared constants and types for the 2x2 Hill key recovery / encrypt core.
// ----------------------------------------------------------------------------
package hkr_pkg;

  localparam int unsigned LETTER_W    = 5;
  localparam int unsigned MODULUS_DEF = 26;
  localparam int unsigned N_LETTERS   = 8;

  localparam logic REQ_RECOVER = 1'b0;
  localparam logic REQ_ENCRYPT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_DET,
    S_INV,
    S_PINV,
    S_KEY,
    S_ENC,
    S_DONE
  } hkr_state_e;

endpackage

FILE: hw/rtl/hkr_chan_if.sv
// ----------------------------------------------------------------------------
// hkr_chan_if
// Request and response channels of the Hill key recovery / encrypt core.
// ----------------------------------------------------------------------------
interface hkr_req_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [hkr_pkg::LETTER_W-1:0]  plain_0;
  logic [hkr_pkg::LETTER_W-1:0]  plain_1;
  logic [hkr_pkg::LETTER_W-1:0]  plain_2;
  logic [hkr_pkg::LETTER_W-1:0]  plain_3;
  logic [hkr_pkg::LETTER_W-1:0]  cipher_0;
  logic [hkr_pkg::LETTER_W-1:0]  cipher_1;
  logic [hkr_pkg::LETTER_W-1:0]  cipher_2;
  logic [hkr_pkg::LETTER_W-1:0]  cipher_3;

  modport source (
    output valid, req_type, plain_0, plain_1, plain_2, plain_3,
           cipher_0, cipher_1, cipher_2, cipher_3,
    input  ready
  );
  modport sink (
    input  valid, req_type, plain_0, plain_1, plain_2, plain_3,
           cipher_0, cipher_1, cipher_2, cipher_3,
    output ready
  );
endinterface

interface hkr_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic [hkr_pkg::LETTER_W-1:0]  key_00;
  logic [hkr_pkg::LETTER_W-1:0]  key_01;
  logic [hkr_pkg::LETTER_W-1:0]  key_10;
  logic [hkr_pkg::LETTER_W-1:0]  key_11;
  logic [hkr_pkg::LETTER_W-1:0]  out_letter_0;
  logic [hkr_pkg::LETTER_W-1:0]  out_letter_1;

  modport source (
    output valid, ok, key_00, key_01, key_10, key_11, out_letter_0, out_letter_1,
    input  ready
  );
  modport sink (
    input  valid, ok, key_00, key_01, key_10, key_11, out_letter_0, out_letter_1,
    output ready
  );
endinterface

FILE: hw/rtl/hill2x2_key_recovery_and_encrypt_core.sv
// ----------------------------------------------------------------------------
// hill2x2_key_recovery_and_encrypt_core
// 2x2 Hill cipher key recovery from a known pair, and digraph encryption.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one transaction per item. req_type 0 recovers the key from
//   four plaintext and four ciphertext letters; req_type 1 encrypts
//   (plain_0, plain_1) with the stored key. rsp_o returns one transaction per
//   item: ok, the stored key and the two output letters.
//   Every step runs on one shared (a*b + c) mod MODULUS unit with a
//   four-stage pipeline; a step issues only once the last result is back, so steps are serial.
//   Encrypt: 6 steps.
//   Recover: 22 steps plus one step per inverse candidate tried
//   (1 to MODULUS-1); a singular matrix stops after the search with ok low
//   and the key untouched.
//   req_i.ready is high only while no item is in work; a new item may be
//   accepted while the previous response still waits on rsp_o.
//   A stalled rsp_o holds its transaction; the next result waits for it.
//   Reset clears the key to zeros and drops rsp_o.valid.
// ----------------------------------------------------------------------------
module hill2x2_key_recovery_and_encrypt_core #(
  parameter int unsigned MODULUS = hkr_pkg::MODULUS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hkr_req_if.sink    req_i,
  hkr_rsp_if.source  rsp_o
);

  localparam int unsigned LW = hkr_pkg::LETTER_W;
  localparam int unsigned RW = $clog2(MODULUS);
  localparam int unsigned AW = (RW > LW) ? RW : LW;
  localparam int unsigned CW = (RW > 3) ? RW : 3;
  localparam logic [RW:0]    MOD_W    = (RW + 1)'(MODULUS);
  localparam logic [CW-1:0]  INV_LAST = CW'(MODULUS - 1);
  localparam logic [RW-1:0]  RES_ONE  = RW'(1);

  function automatic logic [RW-1:0] neg_mod(input logic [RW-1:0] v);
    logic [RW:0] d;
    d = MOD_W - {1'b0, v};
    return (v == '0) ? '0 : d[RW-1:0];
  endfunction

  function automatic logic [LW-1:0] to_letter(input logic [RW-1:0] v);
    logic [AW-1:0] e;
    e = AW'(v);
    return e[LW-1:0];
  endfunction

  hkr_pkg::hkr_state_e state_q, state_d;
  logic [CW-1:0]          idx_q, idx_d;
  logic                   wait_q, wait_d;
  logic                   req_q, req_d;
  logic [7:0][LW-1:0]     raw_q, raw_d;
  logic [3:0][RW-1:0]     p_q, p_d;
  logic [3:0][RW-1:0]     c_q, c_d;
  logic [3:0][RW-1:0]     pi_q, pi_d;
  logic [3:0][RW-1:0]     key_q, key_d;
  logic [RW-1:0]          t_q, t_d;
  logic [RW-1:0]          det_q, det_d;
  logic [RW-1:0]          di_q, di_d;
  logic [RW-1:0]          o0_q, o0_d;
  logic [RW-1:0]          o1_q, o1_d;
  logic                   ok_q, ok_d;

  logic                   rsp_valid_q, rsp_valid_d;
  logic                   rsp_ok_q, rsp_ok_d;
  logic [3:0][LW-1:0]     rsp_key_q, rsp_key_d;
  logic [LW-1:0]          rsp_l0_q, rsp_l0_d;
  logic [LW-1:0]          rsp_l1_q, rsp_l1_d;

  logic                   mm_valid, mm_rvalid;
  logic [AW-1:0]          mm_a, mm_b, mm_c;
  logic [RW-1:0]          mm_r;
  logic                   in_acc;

  hkr_mulmod #(
    .MODULUS (MODULUS)
  ) u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mm_valid),
    .a_i     (mm_a),
    .b_i     (mm_b),
    .c_i     (mm_c),
    .valid_o (mm_rvalid),
    .r_o     (mm_r)
  );

  assign req_i.ready = (state_q == hkr_pkg::S_IDLE);
  assign in_acc      = req_i.valid && req_i.ready;

  // operand select
  always_comb begin
    mm_a = '0;
    mm_b = '0;
    mm_c = '0;
    unique case (state_q)
      hkr_pkg::S_RED: begin
        mm_a = AW'(raw_q[idx_q[2:0]]);
        mm_b = AW'(1);
      end
      hkr_pkg::S_DET: begin
        if (!idx_q[0]) begin
          mm_a = AW'(p_q[1]);
          mm_b = AW'(p_q[2]);
        end else begin
          mm_a = AW'(p_q[0]);
          mm_b = AW'(p_q[3]);
          mm_c = AW'(neg_mod(t_q));
        end
      end
      hkr_pkg::S_INV: begin
        mm_a = AW'(det_q);
        mm_b = AW'(idx_q[RW-1:0]);
      end
      hkr_pkg::S_PINV: begin
        mm_a = AW'(di_q);
        case (idx_q[1:0])
          2'd0:    mm_b = AW'(p_q[3]);
          2'd1:    mm_b = AW'(neg_mod(p_q[1]));
          2'd2:    mm_b = AW'(neg_mod(p_q[2]));
          default: mm_b = AW'(p_q[0]);
        endcase
      end
      hkr_pkg::S_KEY: begin
        mm_a = AW'(pi_q[{idx_q[2], ~idx_q[0]}]);
        mm_b = AW'(c_q[{~idx_q[0], idx_q[1]}]);
        mm_c = idx_q[0] ? AW'(t_q) : '0;
      end
      hkr_pkg::S_ENC: begin
        mm_a = idx_q[0] ? AW'(p_q[0]) : AW'(p_q[1]);
        mm_b = AW'(key_q[{~idx_q[0], idx_q[1]}]);
        mm_c = idx_q[0] ? AW'(t_q) : '0;
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    wait_d      = wait_q;
    req_d       = req_q;
    raw_d       = raw_q;
    p_d         = p_q;
    c_d         = c_q;
    pi_d        = pi_q;
    key_d       = key_q;
    t_d         = t_q;
    det_d       = det_q;
    di_d        = di_q;
    o0_d        = o0_q;
    o1_d        = o1_q;
    ok_d        = ok_q;
    rsp_valid_d = rsp_valid_q;
    rsp_ok_d    = rsp_ok_q;
    rsp_key_d   = rsp_key_q;
    rsp_l0_d    = rsp_l0_q;
    rsp_l1_d    = rsp_l1_q;
    mm_valid    = 1'b0;

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      hkr_pkg::S_IDLE: begin
        if (in_acc) begin
          req_d   = req_i.req_type;
          raw_d   = {req_i.cipher_3, req_i.cipher_2, req_i.cipher_1, req_i.cipher_0,
                     req_i.plain_3, req_i.plain_2, req_i.plain_1, req_i.plain_0};
          o0_d    = '0;
          o1_d    = '0;
          idx_d   = '0;
          wait_d  = 1'b0;
          state_d = hkr_pkg::S_RED;
        end
      end
      hkr_pkg::S_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          rsp_ok_d    = ok_q;
          for (int k = 0; k < 4; k++) begin
            rsp_key_d[k] = to_letter(key_q[k]);
          end
          rsp_l0_d    = to_letter(o0_q);
          rsp_l1_d    = to_letter(o1_q);
          state_d     = hkr_pkg::S_IDLE;
        end
      end
      default: begin
        if (!wait_q) begin
          mm_valid = 1'b1;
          wait_d   = 1'b1;
        end else if (mm_rvalid) begin
          wait_d = 1'b0;
          idx_d  = idx_q + CW'(1);
          unique case (state_q)
            hkr_pkg::S_RED: begin
              if (!idx_q[2]) begin
                p_d[idx_q[1:0]] = mm_r;
              end else begin
                c_d[idx_q[1:0]] = mm_r;
              end
              if (req_q == hkr_pkg::REQ_ENCRYPT && idx_q == CW'(1)) begin
                idx_d   = '0;
                state_d = hkr_pkg::S_ENC;
              end else if (idx_q == CW'(7)) begin
                idx_d   = '0;
                state_d = hkr_pkg::S_DET;
              end
            end
            hkr_pkg::S_DET: begin
              if (!idx_q[0]) begin
                t_d = mm_r;
              end else begin
                det_d   = mm_r;
                idx_d   = CW'(1);
                state_d = hkr_pkg::S_INV;
              end
            end
            hkr_pkg::S_INV: begin
              if (mm_r == RES_ONE) begin
                di_d    = idx_q[RW-1:0];
                idx_d   = '0;
                state_d = hkr_pkg::S_PINV;
              end else if (idx_q == INV_LAST) begin
                ok_d    = 1'b0;
                state_d = hkr_pkg::S_DONE;
              end
            end
            hkr_pkg::S_PINV: begin
              pi_d[idx_q[1:0]] = mm_r;
              if (idx_q == CW'(3)) begin
                idx_d   = '0;
                state_d = hkr_pkg::S_KEY;
              end
            end
            hkr_pkg::S_KEY: begin
              if (!idx_q[0]) begin
                t_d = mm_r;
              end else begin
                key_d[idx_q[2:1]] = mm_r;
              end
              if (idx_q == CW'(7)) begin
                ok_d    = 1'b1;
                state_d = hkr_pkg::S_DONE;
              end
            end
            hkr_pkg::S_ENC: begin
              case (idx_q[1:0])
                2'd1:    o0_d = mm_r;
                2'd3:    o1_d = mm_r;
                default: t_d  = mm_r;
              endcase
              if (idx_q == CW'(3)) begin
                ok_d    = 1'b1;
                state_d = hkr_pkg::S_DONE;
              end
            end
            default: ;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hkr_pkg::S_IDLE;
      idx_q       <= '0;
      wait_q      <= 1'b0;
      key_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      wait_q      <= wait_d;
      key_q       <= key_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    raw_q     <= raw_d;
    p_q       <= p_d;
    c_q       <= c_d;
    pi_q      <= pi_d;
    t_q       <= t_d;
    det_q     <= det_d;
    di_q      <= di_d;
    o0_q      <= o0_d;
    o1_q      <= o1_d;
    ok_q      <= ok_d;
    rsp_ok_q  <= rsp_ok_d;
    rsp_key_q <= rsp_key_d;
    rsp_l0_q  <= rsp_l0_d;
    rsp_l1_q  <= rsp_l1_d;
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.ok           = rsp_ok_q;
  assign rsp_o.key_00       = rsp_key_q[0];
  assign rsp_o.key_01       = rsp_key_q[1];
  assign rsp_o.key_10       = rsp_key_q[2];
  assign rsp_o.key_11       = rsp_key_q[3];
  assign rsp_o.out_letter_0 = rsp_l0_q;
  assign rsp_o.out_letter_1 = rsp_l1_q;

  // a unit result only ever answers an issued step
  a_result_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_rvalid |-> wait_q)
    else $error("mulmod result with no step in flight");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == hkr_pkg::S_RED))
    else $error("accepted transaction did not start reduction");

  a_key_only_in_key_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != hkr_pkg::S_KEY) |=> $stable(key_q))
    else $error("key changed outside key phase");

  a_fail_no_letters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.ok) |-> (rsp_o.out_letter_0 == '0 && rsp_o.out_letter_1 == '0))
    else $error("failed recovery with nonzero output letters");

endmodule

FILE: hw/rtl/hkr_mulmod.sv
// ----------------------------------------------------------------------------
// hkr_mulmod
// Four-stage (a*b + c) mod MODULUS unit, reciprocal-multiply reduction.
// ----------------------------------------------------------------------------
module hkr_mulmod #(
  parameter int unsigned MODULUS = hkr_pkg::MODULUS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [((($clog2(MODULUS)) > hkr_pkg::LETTER_W) ? $clog2(MODULUS)
                 : hkr_pkg::LETTER_W)-1:0] a_i,
  input  logic [((($clog2(MODULUS)) > hkr_pkg::LETTER_W) ? $clog2(MODULUS)
                 : hkr_pkg::LETTER_W)-1:0] b_i,
  input  logic [((($clog2(MODULUS)) > hkr_pkg::LETTER_W) ? $clog2(MODULUS)
                 : hkr_pkg::LETTER_W)-1:0] c_i,
  output logic                valid_o,
  output logic [$clog2(MODULUS)-1:0] r_o
);

  localparam int unsigned RW = $clog2(MODULUS);
  localparam int unsigned AW = (RW > hkr_pkg::LETTER_W) ? RW : hkr_pkg::LETTER_W;
  localparam int unsigned XW = 2 * AW + 1;
  localparam int unsigned PW = 2 * XW;
  localparam longint unsigned RECIP_L = (64'd1 << XW) / MODULUS;
  localparam logic [XW-1:0] RECIP = XW'(RECIP_L);
  localparam logic [XW-1:0] MOD_X = XW'(MODULUS);

  logic [3:0]    v_q;
  logic [XW-1:0] x1_q, x2_q, x3_q;
  logic [PW-1:0] xr_q;
  logic [XW-1:0] qm_q;
  logic [XW-1:0] rem_d, rem_c;
  logic [RW-1:0] r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_comb begin
    rem_d = x3_q - qm_q;
    rem_c = (rem_d >= MOD_X) ? (rem_d - MOD_X) : rem_d;
  end

  always_ff @(posedge clk_i) begin
    x1_q <= XW'(a_i) * XW'(b_i) + XW'(c_i);
    xr_q <= PW'(x1_q) * PW'(RECIP);
    x2_q <= x1_q;
    qm_q <= xr_q[PW-1:XW] * MOD_X;
    x3_q <= x2_q;
    r_q  <= rem_c[RW-1:0];
  end

  assign valid_o = v_q[3];
  assign r_o     = r_q;

endmodule
